// ----- src/upce_pkg.sv -----
`default_nettype none

package upce_pkg;

	// Output formats held in the format register; other codes reject every item
	localparam logic [2:0] FMT_UTF8    = 3'd0;
	localparam logic [2:0] FMT_UTF16LE = 3'd1;
	localparam logic [2:0] FMT_UTF16BE = 3'd2;
	localparam logic [2:0] FMT_UTF32LE = 3'd3;
	localparam logic [2:0] FMT_UTF32BE = 3'd4;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// One classified item: its bytes in stream order, run length minus one,
	// and the error mark
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      len_m1;
		logic            rej;
	} rec_t;

endpackage

`default_nettype wire

// ----- src/upce_front.sv -----
`default_nettype none

module upce_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [2:0]       fmt,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [31:0]      code_point,
	input  wire logic             q_full,
	output logic                  q_wr,
	output upce_pkg::rec_t        q_wdata
);
	import upce_pkg::*;

	logic        valid_s1;
	logic [31:0] cp_s1;
	logic        accept;

	logic        surrogate;
	logic        in_range;
	logic [20:0] v;
	logic [15:0] hi_unit;
	logic [15:0] lo_unit;
	rec_t        rec;

	assign full   = valid_s1 & q_full;
	assign accept = push & ~full;
	assign q_wr   = valid_s1 & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_wr) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cp_s1 <= code_point;
		end
	end

	// D800..DFFF share the upper bits 0x1B from bit 11 up
	assign surrogate = (cp_s1[31:11] == 21'h1B);
	assign in_range  = (cp_s1[31:21] == 11'd0);
	assign v         = cp_s1[20:0] - 21'h10000;
	assign hi_unit   = 16'hD800 | {5'd0, v[20:10]};
	assign lo_unit   = {6'b110111, v[9:0]};

	always_comb begin
		rec = '0;
		if (surrogate || !in_range) begin
			rec.rej = 1'b1;
		end else begin
			unique case (fmt)
				FMT_UTF8: begin
					priority if (cp_s1[20:7] == 14'd0) begin
						rec.bytes[0] = {1'b0, cp_s1[6:0]};
						rec.len_m1   = 2'd0;
					end else if (cp_s1[20:11] == 10'd0) begin
						rec.bytes[0] = {3'b110, cp_s1[10:6]};
						rec.bytes[1] = {2'b10, cp_s1[5:0]};
						rec.len_m1   = 2'd1;
					end else if (cp_s1[20:16] == 5'd0) begin
						rec.bytes[0] = {4'b1110, cp_s1[15:12]};
						rec.bytes[1] = {2'b10, cp_s1[11:6]};
						rec.bytes[2] = {2'b10, cp_s1[5:0]};
						rec.len_m1   = 2'd2;
					end else begin
						rec.bytes[0] = {5'b11110, cp_s1[20:18]};
						rec.bytes[1] = {2'b10, cp_s1[17:12]};
						rec.bytes[2] = {2'b10, cp_s1[11:6]};
						rec.bytes[3] = {2'b10, cp_s1[5:0]};
						rec.len_m1   = 2'd3;
					end
				end
				FMT_UTF16LE, FMT_UTF16BE: begin
					if (cp_s1[20:16] == 5'd0) begin
						rec.bytes[0] = (fmt == FMT_UTF16BE) ? cp_s1[15:8] : cp_s1[7:0];
						rec.bytes[1] = (fmt == FMT_UTF16BE) ? cp_s1[7:0] : cp_s1[15:8];
						rec.len_m1   = 2'd1;
					end else begin
						rec.bytes[0] = (fmt == FMT_UTF16BE) ? hi_unit[15:8] : hi_unit[7:0];
						rec.bytes[1] = (fmt == FMT_UTF16BE) ? hi_unit[7:0] : hi_unit[15:8];
						rec.bytes[2] = (fmt == FMT_UTF16BE) ? lo_unit[15:8] : lo_unit[7:0];
						rec.bytes[3] = (fmt == FMT_UTF16BE) ? lo_unit[7:0] : lo_unit[15:8];
						rec.len_m1   = 2'd3;
					end
				end
				FMT_UTF32LE: begin
					rec.bytes  = {cp_s1[31:24], cp_s1[23:16], cp_s1[15:8], cp_s1[7:0]};
					rec.len_m1 = 2'd3;
				end
				FMT_UTF32BE: begin
					rec.bytes  = {cp_s1[7:0], cp_s1[15:8], cp_s1[23:16], cp_s1[31:24]};
					rec.len_m1 = 2'd3;
				end
				default: begin
					rec.rej = 1'b1;
				end
			endcase
		end
	end

	assign q_wdata = rec;

endmodule

`default_nettype wire

// ----- src/upce_queue.sv -----
`default_nettype none

module upce_queue #(
	parameter int unsigned DEPTH = upce_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr,
	input  wire upce_pkg::rec_t wdata,
	output logic                q_full,
	input  wire logic           rd,
	output logic                q_valid,
	output upce_pkg::rec_t      rdata
);
	import upce_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	rec_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (count_q == FULL_CNT);
	assign q_valid = (count_q != '0);
	assign do_wr   = wr & ~q_full;
	assign do_rd   = rd & q_valid;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ----- src/upce_back.sv -----
`default_nettype none

module upce_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire upce_pkg::rec_t q_rdata,
	output logic                q_rd,
	output logic                empty,
	input  wire logic           pop,
	output logic [7:0]          out_byte,
	output logic                last_byte,
	output logic                rejected
);
	import upce_pkg::*;

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       rej_q;
	logic [1:0] idx_q;
	logic       load;
	logic       is_last;

	assign load    = q_valid & (~out_valid_q | pop);
	assign is_last = (idx_q == q_rdata.len_m1);
	assign q_rd    = load & is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= q_rdata.bytes[idx_q];
			last_q <= is_last;
			rej_q  <= q_rdata.rej;
		end
	end

	assign empty     = ~out_valid_q;
	assign out_byte  = byte_q;
	assign last_byte = last_q;
	assign rejected  = rej_q;

endmodule

`default_nettype wire

// ----- src/unicode_code_point_encoder_core.sv -----
`default_nettype none

// Code point encoder. Each item pushed is a 32-bit code point; it comes out as
// a run of one to four byte items in stream order, the final one flagged by
// last_byte. cfg_wr_data selects the format (0 UTF-8, 1 UTF-16LE, 2 UTF-16BE,
// 3 UTF-32LE, 4 UTF-32BE) and must be written only while the block is idle; the
// block itself does not enforce this. Surrogates, values at or above 0x200000,
// and the undefined format codes give a single item with rejected set, last_byte
// set and a zero byte. UTF-16 pairs for values above 0x10FFFF are written as
// computed, truncated to 16 bits per unit. Throughput is one byte per cycle while
// pop is held, so an item gives as many byte items as it has bytes: one to four,
// four for UTF-8 at or above 0x10000, for UTF-16 pairs and for UTF-32. That
// figure is set by the single-byte output register. An input stage classifies
// the item and writes the whole run into a small queue; the output side drains
// it byte by byte, so a stall on either side leaves the other free. An accepted
// push is held in the front register, then the queue, then the output register.
module unicode_code_point_encoder_core #(
	parameter int unsigned QUEUE_DEPTH = upce_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_wr_data,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] code_point,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             last_byte,
	output logic             rejected
);
	import upce_pkg::*;

	logic [2:0] fmt_q;
	logic       q_wr;
	logic       q_full;
	logic       q_rd;
	logic       q_valid;
	rec_t       q_wdata;
	rec_t       q_rdata;

	// Format register; the front reads it live, which is safe only if the user
	// writes it with nothing in flight; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_UTF8;
		end else if (cfg_wr_en) begin
			fmt_q <= cfg_wr_data;
		end
	end

	// Front: register the code point, classify it and build the byte run
	upce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.fmt        (fmt_q),
		.push       (push),
		.full       (full),
		.code_point (code_point),
		.q_full     (q_full),
		.q_wr       (q_wr),
		.q_wdata    (q_wdata)
	);

	// Queue of whole runs between the two sides
	upce_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wdata   (q_wdata),
		.q_full  (q_full),
		.rd      (q_rd),
		.q_valid (q_valid),
		.rdata   (q_rdata)
	);

	// Back: advance through the head run one byte per item taken; drop the
	// run from the queue as its last byte enters the output register
	upce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_rdata   (q_rdata),
		.q_rd      (q_rd),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.last_byte (last_byte),
		.rejected  (rejected)
	);

`ifndef SYNTHESIS
	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !q_full)
		else $error("front wrote into a full queue");

	a_no_read_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> q_valid)
		else $error("back released a run from an empty queue");

	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rejected) |-> (last_byte && out_byte == 8'd0))
		else $error("rejected item is not a single zero byte");

	a_push_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_full)
		else $error("input blocked while queue had room");
`endif

endmodule

`default_nettype wire

// ----- tb/unicode_code_point_encoder_core_test.sv -----
module unicode_code_point_encoder_core_test;

	import upce_pkg::*;

	// Format codes the block leaves undefined; each rejects every code point
	localparam logic [2:0] FMT_UNDEF5 = 3'd5;
	localparam logic [2:0] FMT_UNDEF7 = 3'd7;

	localparam int RANDOM_ITEMS = 345;
	localparam int QUIET_ITEMS  = 60;   // tail of the run with no idling on either side
	localparam int STALL_LIMIT  = 2000; // cycles without any handshake before giving up
	localparam int SETTLE       = 8;    // margin for anything stray to show after the drain

	// One expected byte item, tagged with its code point for the error report
	typedef struct packed {
		logic [31:0] cp;
		logic [7:0]  octet;
		logic        last;
		logic        rej;
	} byte_exp_t;

	// One directed row; a non-zero n means the bytes are typed in (first byte
	// in the top bits of word), otherwise the encoder model supplies them
	typedef struct {
		logic [2:0]  fmt;
		logic [31:0] cp;
		int unsigned n;
		logic [31:0] word;
		logic        rej;
	} dir_row_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [2:0]  cfg_wr_data = FMT_UTF8;
	logic        push        = 1'b0;
	logic [31:0] code_point  = '0;
	logic        pop         = 1'b0;
	wire         full;
	wire         empty;
	wire  [7:0]  out_byte;
	wire         last_byte;
	wire         rejected;

	// Side channel from the driver to the monitor for typed-in rows
	logic        row_fixed = 1'b0;
	int unsigned row_n     = 0;
	logic [31:0] row_word  = '0;
	logic        row_rej   = 1'b0;

	byte_exp_t   pending_bytes[$];
	dir_row_t    dir_rows[$];
	logic [2:0]  fmt_now = FMT_UTF8; // format the block holds, tracked at the edge
	logic [7:0]  fmts_used = '0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	int          rx_stall_left = 0;
	int          mismatches = 0;
	int          cps_taken = 0;
	int          bytes_checked = 0;
	int          rejects_seen = 0;
	int          quiet_cycles = 0;

	unicode_code_point_encoder_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.push       (push),
		.full       (full),
		.code_point (code_point),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.last_byte  (last_byte),
		.rejected   (rejected)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out the byte run for one code point in the given format. Returns the
	// number of bytes; a refused code point gives one zero byte with bad set.
	function automatic int encode_cp(input logic [2:0] fmt, input logic [31:0] cp,
			output logic [3:0][7:0] enc, output logic bad);
		logic [31:0] v;
		logic [15:0] hi_unit;
		logic [15:0] lo_unit;
		int          n;
		enc = '0;
		n   = 0;
		v   = cp - 32'h10000;
		case (fmt)
			FMT_UTF8: begin
				if (cp < 32'h80) begin
					enc[0] = cp[7:0];
					n = 1;
				end else if (cp < 32'h800) begin
					enc[0] = 8'hC0 | cp[10:6];
					enc[1] = 8'h80 | cp[5:0];
					n = 2;
				end else if (cp < 32'h10000) begin
					enc[0] = 8'hE0 | cp[15:12];
					enc[1] = 8'h80 | cp[11:6];
					enc[2] = 8'h80 | cp[5:0];
					n = 3;
				end else if (cp < 32'h200000) begin
					enc[0] = 8'hF0 | cp[20:18];
					enc[1] = 8'h80 | cp[17:12];
					enc[2] = 8'h80 | cp[11:6];
					enc[3] = 8'h80 | cp[5:0];
					n = 4;
				end
			end
			FMT_UTF16LE, FMT_UTF16BE: begin
				// Pairs above the Unicode range are kept, each unit cut to 16 bits
				if (cp < 32'h10000) begin
					hi_unit = cp[15:0];
					n = 2;
				end else if (cp < 32'h200000) begin
					hi_unit = 16'hD800 | v[25:10];
					lo_unit = 16'hDC00 | v[9:0];
					n = 4;
				end
				if (n != 0) begin
					if (fmt == FMT_UTF16BE) begin
						enc[0] = hi_unit[15:8];
						enc[1] = hi_unit[7:0];
						enc[2] = lo_unit[15:8];
						enc[3] = lo_unit[7:0];
					end else begin
						enc[0] = hi_unit[7:0];
						enc[1] = hi_unit[15:8];
						enc[2] = lo_unit[7:0];
						enc[3] = lo_unit[15:8];
					end
				end
			end
			FMT_UTF32LE: begin
				if (cp <= 32'h1FFFFF) begin
					enc = {cp[31:24], cp[23:16], cp[15:8], cp[7:0]};
					n = 4;
				end
			end
			FMT_UTF32BE: begin
				if (cp <= 32'h1FFFFF) begin
					enc = {cp[7:0], cp[15:8], cp[23:16], cp[31:24]};
					n = 4;
				end
			end
			default: n = 0;
		endcase
		// Surrogates are refused whatever the format
		if (cp >= 32'hD800 && cp <= 32'hDFFF)
			n = 0;
		bad = (n == 0);
		if (bad) begin
			enc = '0;
			n = 1;
		end
		return n;
	endfunction

	// Pick a code point, weighted towards each encoding band and its borders
	function automatic logic [31:0] rand_cp();
		logic [31:0] r;
		case ($urandom_range(0, 11))
			0:       r = $urandom_range(0, 32'h7F);
			1:       r = $urandom_range(32'h80, 32'h7FF);
			2:       r = $urandom_range(32'h800, 32'hD7FF);
			3:       r = $urandom_range(32'hD800, 32'hDFFF);
			4:       r = $urandom_range(32'hE000, 32'hFFFF);
			5:       r = $urandom_range(32'h10000, 32'h10FFFF);
			6:       r = $urandom_range(32'h110000, 32'h1FFFFF);
			7: begin
				case ($urandom_range(0, 11))
					0:       r = 32'h7F;
					1:       r = 32'h80;
					2:       r = 32'h7FF;
					3:       r = 32'h800;
					4:       r = 32'hD7FF;
					5:       r = 32'hD800;
					6:       r = 32'hDFFF;
					7:       r = 32'hE000;
					8:       r = 32'hFFFF;
					9:       r = 32'h10000;
					10:      r = 32'h1FFFFF;
					default: r = 32'h200000;
				endcase
			end
			8, 9:    r = $urandom();
			default: r = $urandom_range(0, 32'h1FFFFF);
		endcase
		return r;
	endfunction

	// Result side: stall in random bursts while idling is enabled
	always @(negedge clk) begin
		if (rx_stall_left != 0) begin
			pop = 1'b0;
			rx_stall_left--;
		end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
			pop = 1'b0;
			rx_stall_left = $urandom_range(0, 12);
		end else begin
			pop = 1'b1;
		end
	end

	// Monitor: check each byte item leaving the block, then queue the run
	// expected for any code point taken in at the same edge
	always @(posedge clk) begin
		logic [3:0][7:0] enc;
		logic            bad;
		int              n;
		int              k;
		byte_exp_t       want;
		if (arst_n) begin
			if (pop && !empty) begin
				bytes_checked++;
				if (rejected === 1'b1)
					rejects_seen++;
				if (pending_bytes.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected byte item: byte %02h last %b rejected %b",
							out_byte, last_byte, rejected);
					mismatches++;
				end else begin
					want = pending_bytes.pop_front();
					if (out_byte !== want.octet || last_byte !== want.last ||
							rejected !== want.rej) begin
						if (mismatches < 10)
							$display("mismatch for code point %08h: expected %02h/%b/%b got %02h/%b/%b",
								want.cp, want.octet, want.last, want.rej,
								out_byte, last_byte, rejected);
						mismatches++;
					end
				end
			end
			if (push && !full) begin
				cps_taken++;
				fmts_used[fmt_now] = 1'b1;
				if (row_fixed) begin
					n   = row_n;
					bad = row_rej;
					for (k = 0; k < n; k++)
						enc[k] = row_word[8*(n-1-k) +: 8];
				end else begin
					n = encode_cp(fmt_now, code_point, enc, bad);
				end
				for (k = 0; k < n; k++)
					pending_bytes.push_back('{cp: code_point, octet: enc[k],
						last: (k == n - 1), rej: bad});
			end
			if (cfg_wr_en)
				fmt_now = cfg_wr_data;
		end
	end

	// Watchdog: end the run if nothing moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || cfg_wr_en)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("no handshake for %0d cycles, %0d byte items outstanding",
					quiet_cycles, pending_bytes.size());
				$display("unicode_code_point_encoder_core_test NOT OK");
				$finish;
			end
		end
	end

	task automatic add_row(input logic [2:0] fmt, input logic [31:0] cp, input int unsigned n,
			input logic [31:0] word, input logic rej);
		dir_rows.push_back('{fmt, cp, n, word, rej});
	endtask

	// Hold the push side low, let every expected byte drain, then write the format
	task automatic set_format(input logic [2:0] fmt);
		push      = 1'b0;
		row_fixed = 1'b0;
		while (pending_bytes.size() != 0)
			@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = fmt;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Offer one code point, with an optional random gap first; return at the
	// falling edge after it is taken, leaving push high for the next item
	task automatic send_cp(input logic [31:0] cp, input int unsigned fixed_n,
			input logic [31:0] fixed_word, input logic fixed_rej);
		int unsigned gap;
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			gap  = $urandom_range(1, 13);
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push       = 1'b1;
		code_point = cp;
		row_fixed  = (fixed_n != 0);
		row_n      = fixed_n;
		row_word   = fixed_word;
		row_rej    = fixed_rej;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	initial begin
		dir_row_t r;
		int       n_random;
		int       batch;
		int       i;
		logic [2:0] fmt;

		// UTF-8 straight out of reset: band edges, surrogates and the upper limit
		add_row(FMT_UTF8,    32'h0,        1, 32'h00,       1'b0);
		add_row(FMT_UTF8,    32'h7F,       1, 32'h7F,       1'b0);
		add_row(FMT_UTF8,    32'h80,       0, '0,           1'b0);
		add_row(FMT_UTF8,    32'h7FF,      0, '0,           1'b0);
		add_row(FMT_UTF8,    32'h800,      0, '0,           1'b0);
		add_row(FMT_UTF8,    32'hD7FF,     0, '0,           1'b0);
		add_row(FMT_UTF8,    32'hD800,     1, 32'h00,       1'b1);
		add_row(FMT_UTF8,    32'hDFFF,     1, 32'h00,       1'b1);
		add_row(FMT_UTF8,    32'hE000,     0, '0,           1'b0);
		add_row(FMT_UTF8,    32'hFFFF,     0, '0,           1'b0);
		add_row(FMT_UTF8,    32'h10000,    0, '0,           1'b0);
		add_row(FMT_UTF8,    32'h1FFFFF,   4, 32'hF7BFBFBF, 1'b0);
		add_row(FMT_UTF8,    32'h200000,   1, 32'h00,       1'b1);
		add_row(FMT_UTF8,    32'hFFFFFFFF, 1, 32'h00,       1'b1);
		// UTF-16: top of Unicode, and a pair beyond it cut to 16 bits per unit
		add_row(FMT_UTF16LE, 32'h10FFFF,   0, '0,           1'b0);
		add_row(FMT_UTF16LE, 32'h1FFFFF,   0, '0,           1'b0);
		add_row(FMT_UTF16BE, 32'h10000,    0, '0,           1'b0);
		add_row(FMT_UTF16BE, 32'h200000,   1, 32'h00,       1'b1);
		// UTF-32 both ways round, at and past the limit, and a surrogate
		add_row(FMT_UTF32LE, 32'h1FFFFF,   4, 32'hFFFF1F00, 1'b0);
		add_row(FMT_UTF32LE, 32'h200000,   1, 32'h00,       1'b1);
		add_row(FMT_UTF32BE, 32'h1FFFFF,   4, 32'h001FFFFF, 1'b0);
		add_row(FMT_UTF32BE, 32'hDABC,     1, 32'h00,       1'b1);
		// Undefined formats refuse everything, the all-ones code among them
		add_row(FMT_UNDEF7,  32'h41,       1, 32'h00,       1'b1);
		add_row(FMT_UNDEF5,  32'h0,        1, 32'h00,       1'b1);
		add_row(FMT_UTF32BE + 3'd2, 32'h10000, 1, 32'h00,   1'b1);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed rows; write the format only where it changes
		foreach (dir_rows[j]) begin
			r = dir_rows[j];
			if (r.fmt != fmt_now)
				set_format(r.fmt);
			send_cp(r.cp, r.n, r.word, r.rej);
		end

		// Random phases, each with its own format and idling mix; the tail runs flat out
		n_random = 0;
		while (n_random < RANDOM_ITEMS) begin
			if (n_random >= RANDOM_ITEMS - QUIET_ITEMS) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end else begin
				tx_idle_on = ($urandom_range(0, 3) != 0);
				rx_idle_on = ($urandom_range(0, 3) != 0);
			end
			i = $urandom_range(0, 11);
			if (i < 10)
				fmt = 3'(i % (FMT_UTF32BE + 1));
			else
				fmt = 3'($urandom_range(FMT_UNDEF5, FMT_UNDEF7));
			set_format(fmt);
			batch = $urandom_range(8, 40);
			for (i = 0; i < batch && n_random < RANDOM_ITEMS; i++) begin
				send_cp(rand_cp(), 0, '0, 1'b0);
				n_random++;
			end
		end

		// Drain, then allow a few more cycles for anything stray to show
		push      = 1'b0;
		row_fixed = 1'b0;
		while (pending_bytes.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("encoded %0d code points into %0d checked byte items, %0d of them rejections",
			cps_taken, bytes_checked, rejects_seen);
		$display("formats exercised (bit per code): %b, mismatches: %0d", fmts_used, mismatches);
		if (mismatches == 0)
			$display("unicode_code_point_encoder_core_test OK");
		else
			$display("unicode_code_point_encoder_core_test NOT OK");
		$finish;
	end

endmodule
